/* rtl/core/bed_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types and constants for the backslash escape decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

  // Most result bytes one item can cause
  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  // Default depth of the job queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgEscapesOn = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNoNewline = 2'd1;

  // Command codes of the input item
  localparam logic CmdChar   = 1'b0;
  localparam logic CmdArgEnd = 1'b1;

  // Byte constants
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChLowX    = 8'h78;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChBell    = 8'd7;
  localparam logic [7:0] ChBack    = 8'd8;
  localparam logic [7:0] ChEsc     = 8'd27;
  localparam logic [7:0] ChFeed    = 8'd12;
  localparam logic [7:0] ChCr      = 8'd13;
  localparam logic [7:0] ChTab     = 8'd9;
  localparam logic [7:0] ChVtab    = 8'd11;

  // Escape parser state, one-hot
  typedef enum logic [3:0] {
    ModeNormal = 4'b0001,
    ModeBslash = 4'b0010,
    ModeHex0   = 4'b0100,
    ModeHex1   = 4'b1000
  } parse_mode_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
    logic       final_arg;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic escapes_on;
    logic no_newline;
  } cfg_t;

  // One classified item: its result bytes in order and how many there are
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CntW-1:0]            cnt;
  } job_t;

  // Head of the job queue as seen by the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } queue_head_t;

endpackage

/* rtl/core/bed_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_front
// Accepts items, tracks escape parse state and turns each item into a job
// of zero to three result bytes.
// ----------------------------------------------------------------------------
module bed_front import bed_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_stall_o,
  input  logic     q_full_i,
  output logic     push_o,
  output job_t     job_o
);

  parse_mode_e mode_q, mode_d;
  logic [3:0]  hex_q, hex_d;
  logic        stop_q, stop_d;
  logic        accept;
  logic [4:0]  hv;
  logic        hv_bad;
  logic [7:0]  term;
  job_t        job;

  // Hex digit value, bit 4 set for a non-hex character
  always_comb begin
    hv = 5'h10;
    if (in_item_i.ch >= "0" && in_item_i.ch <= "9") begin
      hv = {1'b0, 4'(in_item_i.ch - "0")};
    end else if (in_item_i.ch >= "a" && in_item_i.ch <= "f") begin
      hv = {1'b0, 4'(in_item_i.ch - "a" + 8'd10)};
    end else if (in_item_i.ch >= "A" && in_item_i.ch <= "F") begin
      hv = {1'b0, 4'(in_item_i.ch - "A" + 8'd10)};
    end
  end
  assign hv_bad = hv[4];

  assign term = (!cfg_i.no_newline && in_item_i.final_arg) ? ChNewline : ChSpace;

  // Classify the item and work out the next parse state
  always_comb begin
    job    = '0;
    mode_d = mode_q;
    hex_d  = hex_q;
    stop_d = stop_q;
    if (in_item_i.cmd == CmdChar) begin
      if (stop_q) begin
        mode_d = ModeNormal;
        hex_d  = '0;
      end else if (!cfg_i.escapes_on) begin
        mode_d       = ModeNormal;
        hex_d        = '0;
        job.bytes[0] = in_item_i.ch;
        job.cnt      = CntW'(1);
      end else begin
        unique case (mode_q)
          ModeNormal: begin
            if (in_item_i.ch == ChBslash) begin
              mode_d = ModeBslash;
            end else begin
              job.bytes[0] = in_item_i.ch;
              job.cnt      = CntW'(1);
            end
          end
          ModeBslash: begin
            mode_d  = ModeNormal;
            job.cnt = CntW'(1);
            unique case (in_item_i.ch)
              ChBslash: job.bytes[0] = ChBslash;
              "a":      job.bytes[0] = ChBell;
              "b":      job.bytes[0] = ChBack;
              "e":      job.bytes[0] = ChEsc;
              "f":      job.bytes[0] = ChFeed;
              "n":      job.bytes[0] = ChNewline;
              "r":      job.bytes[0] = ChCr;
              "t":      job.bytes[0] = ChTab;
              "v":      job.bytes[0] = ChVtab;
              "c": begin
                stop_d  = 1'b1;
                job.cnt = '0;
              end
              "0":      job.cnt = '0;
              ChLowX: begin
                mode_d  = ModeHex0;
                job.cnt = '0;
              end
              default: begin
                // unknown escape echoes backslash and the character
                job.bytes[0] = ChBslash;
                job.bytes[1] = in_item_i.ch;
                job.cnt      = CntW'(2);
              end
            endcase
          end
          ModeHex0: begin
            if (hv_bad) begin
              job.bytes[0] = ChBslash;
              job.bytes[1] = ChLowX;
              job.bytes[2] = in_item_i.ch;
              job.cnt      = CntW'(3);
              mode_d       = ModeNormal;
            end else begin
              hex_d  = hv[3:0];
              mode_d = ModeHex1;
            end
          end
          ModeHex1: begin
            if (hv_bad) begin
              job.bytes[0] = {4'h0, hex_q};
              job.bytes[1] = in_item_i.ch;
              job.cnt      = CntW'(2);
            end else begin
              job.bytes[0] = {hex_q, hv[3:0]};
              job.cnt      = CntW'(1);
            end
            hex_d  = '0;
            mode_d = ModeNormal;
          end
          default: begin
            mode_d = ModeNormal;
            hex_d  = '0;
          end
        endcase
      end
    end else begin
      // end of argument: flush a pending backslash or single hex digit, then the separator
      if (!stop_q) begin
        if (mode_q == ModeBslash) begin
          job.bytes[0] = ChBslash;
          job.bytes[1] = term;
          job.cnt      = CntW'(2);
        end else if (mode_q == ModeHex1) begin
          job.bytes[0] = {4'h0, hex_q};
          job.bytes[1] = term;
          job.cnt      = CntW'(2);
        end else begin
          job.bytes[0] = term;
          job.cnt      = CntW'(1);
        end
      end
      mode_d = ModeNormal;
      hex_d  = '0;
      if (in_item_i.final_arg) begin
        stop_d = 1'b0;
      end
    end
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && (job.cnt != '0);
  assign job_o      = job;

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      hex_q  <= '0;
      stop_q <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      stop_q <= stop_d;
    end
  end

endmodule

/* rtl/core/bed_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_queue
// Short job queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bed_queue import bed_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  job_t        job_i,
  output logic        full_o,
  input  logic        pop_i,
  output queue_head_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);

  job_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == CntQW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntQW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntQW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Job storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

/* rtl/core/bed_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_back
// Walks the head job byte by byte into the output register, marking the
// final byte of each item.
// ----------------------------------------------------------------------------
module bed_back import bed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_head_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  output out_item_t   out_item_o,
  input  logic        out_stall_i
);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q;
  logic            load;
  logic            is_last;

  // Load a byte when the output register is free or being taken
  assign load    = head_i.valid && (!out_valid_q || !out_stall_i);
  assign is_last = (CntW'(idx_q) == head_i.job.cnt - CntW'(1));
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = is_last ? '0 : idx_q + IdxW'(1);
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte <= head_i.job.bytes[idx_q];
      out_q.last     <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* rtl/core/backslash_escape_decoder.sv */
`timescale 1ns / 1ps
// The first result byte of an item passes through the job queue and then the
//   output register; further bytes of the same item follow one per cycle while the output does not stall.
// Throughput: one item per cycle while items yield at most one byte; the
//   output register moves one byte per cycle, so an item with several bytes holds
//   the back end until all its bytes are out, with QueueDepth jobs buffered in between.
// Reset: asynchronous, active low; clears parse state, queue and config.
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// Echo-style escape decoder: front end parses, queue buffers jobs, back end
// serializes result bytes.
// ----------------------------------------------------------------------------
module backslash_escape_decoder import bed_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  in_item_t           in_item_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output out_item_t          out_item_o,
  input  logic               out_stall_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic               cfg_data_i
);

  cfg_t        cfg_q;
  logic        q_full;
  logic        push;
  job_t        job;
  logic        pop;
  queue_head_t head;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgEscapesOn) begin
        cfg_q.escapes_on <= cfg_data_i;
      end else if (cfg_index_i == CfgNoNewline) begin
        cfg_q.no_newline <= cfg_data_i;
      end
    end
  end

  bed_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job)
  );

  bed_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  bed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  // Checks
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full) else $error("job pushed into full queue");

  a_job_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (job.cnt != '0) && (job.cnt <= CntW'(MaxResults)))
    else $error("pushed job has bad byte count");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid) else $error("pop from empty queue");

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o && out_item_o.last)
    else $error("finished job did not end with a last byte");

endmodule

/* dv/backslash_escape_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backslash_escape_decoder_tb
// Feeds argument characters and argument ends through the escape decoder
// under several escape / newline settings. Each accepted item is decoded by
// a local escape decoder and the bytes it yields are queued, then matched in
// order against the result items, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_tb;
  import bed_pkg::*;

  localparam int unsigned QuietLimit  = 1000;  // cycles with no handshake
  localparam int unsigned DrainCycles = 8;     // settle time after last byte
  localparam logic [4:0]  HexBad      = 5'h10;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  in_item_t           in_item_i   = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  out_item_t          out_item_o;
  logic               out_stall_i = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic               cfg_data_i  = 1'b0;

  backslash_escape_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Items waiting to be sent, and decoded bytes waiting to come out
  in_item_t    pending_items[$];
  out_item_t   expected_bytes[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned calm_left[2] = '{0, 0};  // no-idle stretches: 0 sender, 1 receiver

  // Local decoder state and register copies
  parse_mode_e dec_mode    = ModeNormal;
  logic [3:0]  dec_hex_hi  = 4'h0;
  logic        dec_stopped = 1'b0;
  logic        esc_on_q    = 1'b0;
  logic        no_nl_q     = 1'b0;

  // Hold length for one side: mostly none, some short, a few long
  function automatic int unsigned draw_hold(input int side);
    int unsigned r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left[side] = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") d = c - "A" + 8'd10;
    else return HexBad;
    return {1'b0, d[3:0]};
  endfunction

  // Decode one item and queue the bytes it yields
  function automatic void decode_item(input in_item_t it);
    logic [7:0] outs[$];
    logic [4:0] nib;
    out_item_t  res;
    if (it.cmd == CmdChar) begin
      if (dec_stopped) begin
        dec_mode   = ModeNormal;
        dec_hex_hi = 4'h0;
      end else if (!esc_on_q) begin
        // pass through; any pending escape is dropped
        dec_mode   = ModeNormal;
        dec_hex_hi = 4'h0;
        outs.push_back(it.ch);
      end else begin
        case (dec_mode)
          ModeNormal: begin
            if (it.ch == ChBslash) dec_mode = ModeBslash;
            else outs.push_back(it.ch);
          end
          ModeBslash: begin
            dec_mode = ModeNormal;
            case (it.ch)
              ChBslash: outs.push_back(ChBslash);
              "a":      outs.push_back(ChBell);
              "b":      outs.push_back(ChBack);
              "c":      dec_stopped = 1'b1;
              "e":      outs.push_back(ChEsc);
              "f":      outs.push_back(ChFeed);
              "n":      outs.push_back(ChNewline);
              "r":      outs.push_back(ChCr);
              "t":      outs.push_back(ChTab);
              "v":      outs.push_back(ChVtab);
              "0":      ;
              ChLowX:   dec_mode = ModeHex0;
              default: begin
                outs.push_back(ChBslash);
                outs.push_back(it.ch);
              end
            endcase
          end
          ModeHex0: begin
            nib = hex_nibble(it.ch);
            if (nib == HexBad) begin
              // not a hex digit: echo the raw sequence
              outs.push_back(ChBslash);
              outs.push_back(ChLowX);
              outs.push_back(it.ch);
              dec_mode = ModeNormal;
            end else begin
              dec_hex_hi = nib[3:0];
              dec_mode   = ModeHex1;
            end
          end
          default: begin
            nib = hex_nibble(it.ch);
            if (nib == HexBad) begin
              outs.push_back({4'h0, dec_hex_hi});
              outs.push_back(it.ch);
            end else begin
              outs.push_back({dec_hex_hi, nib[3:0]});
            end
            dec_hex_hi = 4'h0;
            dec_mode   = ModeNormal;
          end
        endcase
      end
    end else begin
      // argument end: flush a pending backslash or single hex digit, then the separator
      if (!dec_stopped) begin
        if (dec_mode == ModeBslash) outs.push_back(ChBslash);
        else if (dec_mode == ModeHex1) outs.push_back({4'h0, dec_hex_hi});
        outs.push_back((!no_nl_q && it.final_arg) ? ChNewline : ChSpace);
      end
      dec_mode   = ModeNormal;
      dec_hex_hi = 4'h0;
      if (it.final_arg) dec_stopped = 1'b0;
    end
    foreach (outs[k]) begin
      res.out_byte = outs[k];
      res.last     = (k == outs.size() - 1);
      expected_bytes.push_back(res);
    end
  endfunction

  // Sender: one item per slot, random gap after each
  int unsigned send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) decode_item(in_item_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          send_gap = draw_hold(0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted byte, stall at random
  int unsigned stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected item: out_byte %0h last %0b", out_item_o.out_byte,
                 out_item_o.last);
          mismatches++;
        end else begin
          if (out_item_o.out_byte !== expected_bytes[0].out_byte) begin
            $error("out_byte: expected %0h, got %0h", expected_bytes[0].out_byte,
                   out_item_o.out_byte);
            mismatches++;
          end
          if (out_item_o.last !== expected_bytes[0].last) begin
            $error("last: expected %0b, got %0b", expected_bytes[0].last,
                   out_item_o.last);
            mismatches++;
          end
          void'(expected_bytes.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = draw_hold(1);
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(0, 21);
    if (r < 10) c = 8'("0" + r);
    else if (r < 16) c = 8'("a" + r - 10);
    else c = 8'("A" + r - 16);
    return c;
  endfunction

  function automatic logic [7:0] rand_escape_letter();
    case ($urandom_range(0, 8))
      0:       return ChBslash;
      1:       return "a";
      2:       return "b";
      3:       return "e";
      4:       return "f";
      5:       return "n";
      6:       return "r";
      7:       return "t";
      default: return "v";
    endcase
  endfunction

  function automatic void push_char(input logic [7:0] c);
    in_item_t it;
    it.cmd       = CmdChar;
    it.ch        = c;
    it.final_arg = 1'($urandom_range(0, 1));
    pending_items.push_back(it);
  endfunction

  function automatic void push_end(input logic fin);
    in_item_t it;
    it.cmd       = CmdArgEnd;
    it.ch        = rand_byte();
    it.final_arg = fin;
    pending_items.push_back(it);
  endfunction

  // One random chunk, with escapes that are mostly well-formed; returns items added
  function automatic int add_phrase();
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      c = rand_byte();
      if (c == ChBslash) c = ChSpace;
      push_char(c);
      return 1;
    end
    if (r < 45) begin
      push_char(ChBslash);
      push_char(rand_escape_letter());
      return 2;
    end
    if (r < 49) begin
      push_char(ChBslash);
      push_char("0");
      return 2;
    end
    if (r < 52) begin
      push_char(ChBslash);
      push_char("c");
      return 2;
    end
    if (r < 67) begin
      push_char(ChBslash);
      push_char(ChLowX);
      push_char(rand_hex_char());
      if ($urandom_range(0, 1)) begin
        push_char(rand_hex_char());
        return 4;
      end
      return 3;
    end
    if (r < 71) begin
      push_char(ChBslash);
      push_char(ChLowX);
      push_char(rand_byte());
      return 3;
    end
    if (r < 75) begin
      push_char(ChBslash);
      push_char(rand_byte());
      return 2;
    end
    if (r < 86) begin
      push_end($urandom_range(0, 9) < 3);
      return 1;
    end
    push_char(rand_byte());
    return 1;
  endfunction

  // Wait until every item is sent and every byte has come out
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_bytes.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CfgEscapesOn) esc_on_q = val;
    else no_nl_q = val;
    @(negedge clk_i);
  endtask

  task automatic run_random(input int n);
    int k;
    k = 0;
    while (k < n) k += add_phrase();
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: escapes off, backslash passes as is
    push_char(ChBslash);
    push_char("n");
    push_char(8'hFF);
    push_end(1'b0);
    push_end(1'b1);
    wait_drained();

    // Escape decoding: hex forms, bad digits, unknown letter, trailing forms
    write_reg(CfgEscapesOn, 1'b1);
    push_char(ChBslash); push_char(ChLowX); push_char("4"); push_char("1");
    push_char(ChBslash); push_char(ChLowX); push_char("g");
    push_char(ChBslash); push_char(ChLowX); push_char("F"); push_char("z");
    push_char(ChBslash); push_char("q");
    push_char(ChBslash); push_char("0");
    push_char(ChBslash); push_end(1'b0);
    push_char(ChBslash); push_char(ChLowX); push_end(1'b0);
    push_char(ChBslash); push_char(ChLowX); push_char("5"); push_end(1'b1);
    // stop output, then the final argument end clears it
    push_char(ChBslash); push_char("c"); push_char("a"); push_end(1'b0);
    push_end(1'b1);
    // leave a backslash pending across the switch to escapes off
    push_char(ChBslash);
    wait_drained();

    write_reg(CfgEscapesOn, 1'b0);
    push_end(1'b0);
    run_random(70);

    write_reg(CfgEscapesOn, 1'b1);
    write_reg(CfgNoNewline, 1'b1);
    run_random(110);

    write_reg(CfgNoNewline, 1'b0);
    run_random(120);

    write_reg(CfgEscapesOn, 1'b0);
    write_reg(CfgNoNewline, 1'b1);
    run_random(40);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
